// ----- rtl/lkvc_pkg.sv -----
// shared constants and types for the lru key-value cache
package lkvc_pkg;

    // default geometry of the cache
    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CFG_W      = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_ENTRIES_IN_USE = 1'b0
    } reg_idx_t;

    // request kinds carried on s_tuser
    typedef enum logic [0:0] {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } op_t;

endpackage

// ----- rtl/lkvc_ram.sv -----
// generic simple dual-port ram with registered read
module lkvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// fully associative key-value cache with least-recently-used replacement
//
//  channel   | ports                         | beat contents
//  ----------+-------------------------------+----------------------------------------
//  request   | s_tvalid s_tready s_tdata/user| tuser: operation; tdata: key, value
//  result    | m_tvalid m_tready m_tdata/user| tuser: found; tdata: read_value
//  config    | psel penable pwrite paddr ... | entries_in_use at byte address 0
//
//  the single ram read port sweeps all entries to match the key and find the oldest and a
//  free slot, then sweeps again to read, re-age and write back every entry; a get miss
//  skips the second sweep. one request is in work at a time; s_tready is high only in idle.
//  a finished result waits in the output register and the next request is taken meanwhile;
//  that request stalls in its last cycle until the register is free.
//  reset is synchronous; valid bits and occupancy clear at once, no clearing pass.
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // request channel
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // lookup_key, store_value, zero pad
    input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]  s_tdata,
    // operation
    input  logic                                      s_tuser,
    // result channel
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // read_value, zero pad
    output logic [((VALUE_BITS+7)/8)*8-1:0]           m_tdata,
    // found
    output logic                                      m_tuser,
    // configuration port
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [APB_ADDR_W-1:0]                     paddr,
    input  logic [APB_DATA_W-1:0]                     pwdata,
    output logic [APB_DATA_W-1:0]                     prdata,
    output logic                                      pready
);

    localparam int IW     = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int WORD_W = KEY_BITS + VALUE_BITS + IW;
    localparam int M_DATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    // control registers
    state_t                state_reg, state_next;
    logic [CAPACITY-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic [CFG_W-1:0]      cfg_reg, cfg_next;
    logic [CNT_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic                  hit_found_reg, hit_found_next;
    logic                  old_found_reg, old_found_next;
    logic                  free_found_reg, free_found_next;
    logic                  out_valid_reg, out_valid_next;

    // payload registers
    logic [IW-1:0]         rd_idx_reg, rd_idx_next;
    logic                  req_set_reg, req_set_next;
    logic [KEY_BITS-1:0]   req_key_reg, req_key_next;
    logic [VALUE_BITS-1:0] req_val_reg, req_val_next;
    logic [IW-1:0]         hit_idx_reg, hit_idx_next;
    logic [IW-1:0]         hit_age_reg, hit_age_next;
    logic [VALUE_BITS-1:0] hit_val_reg, hit_val_next;
    logic [IW-1:0]         old_idx_reg, old_idx_next;
    logic [IW-1:0]         old_age_reg, old_age_next;
    logic [IW-1:0]         free_idx_reg, free_idx_next;
    logic [IW-1:0]         tgt_idx_reg, tgt_idx_next;
    logic [VALUE_BITS-1:0] tgt_val_reg, tgt_val_next;
    logic [IW-1:0]         thresh_reg, thresh_next;
    logic                  inc_all_reg, inc_all_next;
    logic                  out_found_reg, out_found_next;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;

    // ram interface
    logic                  rd_en;
    logic [WORD_W-1:0]     rd_data;
    logic                  wr_en;
    logic [WORD_W-1:0]     wr_data;
    logic [KEY_BITS-1:0]   ent_key;
    logic [VALUE_BITS-1:0] ent_val;
    logic [IW-1:0]         ent_age;
    logic                  ent_valid;

    // limit and decision
    logic [CMP_W-1:0]      limit_eff;
    logic                  at_limit;
    logic                  evict;
    logic [IW-1:0]         slot;
    logic                  cfg_wr;

    // entry store: {age, value, key}
    lkvc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (rd_idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_cnt_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    assign ent_key   = rd_data[KEY_BITS-1:0];
    assign ent_val   = rd_data[KEY_BITS+VALUE_BITS-1:KEY_BITS];
    assign ent_age   = rd_data[WORD_W-1:KEY_BITS+VALUE_BITS];
    assign ent_valid = valid_reg[rd_idx_reg];

    // sweep reads in both passes
    assign rd_en = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE))
                   && (rd_cnt_reg < CNT_W'(CAPACITY));

    // write-back in the update pass
    assign wr_en = (state_reg == ST_UPDATE) && rd_pend_reg;
    always_comb begin
        if (rd_idx_reg == tgt_idx_reg) begin
            wr_data = {IW'(0), tgt_val_reg, req_key_reg};
        end else if (ent_valid && (inc_all_reg || (ent_age < thresh_reg))) begin
            wr_data = {ent_age + IW'(1), ent_val, ent_key};
        end else begin
            wr_data = rd_data;
        end
    end

    // effective limit: zero acts as one, above capacity acts as capacity
    assign limit_eff = (cfg_reg == '0) ? CMP_W'(1) : CMP_W'(cfg_reg);
    assign at_limit  = (CMP_W'(occ_reg) >= limit_eff) || (occ_reg >= CNT_W'(CAPACITY));
    assign evict     = req_set_reg && !hit_found_reg && at_limit && old_found_reg;
    always_comb begin
        if (evict && !(free_found_reg && (free_idx_reg < old_idx_reg))) begin
            slot = old_idx_reg;
        end else begin
            slot = free_idx_reg;
        end
    end

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (reg_idx_t'(paddr[2]) == REG_ENTRIES_IN_USE);
    assign cfg_next = cfg_wr ? pwdata[CFG_W-1:0] : cfg_reg;
    always_comb begin
        if (reg_idx_t'(paddr[2]) == REG_ENTRIES_IN_USE) begin
            prdata = APB_DATA_W'(cfg_reg);
        end else begin
            prdata = '0;
        end
    end

    // handshake outputs
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = M_DATA_W'(out_value_reg);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        rd_cnt_next     = rd_en ? rd_cnt_reg + CNT_W'(1) : rd_cnt_reg;
        rd_pend_next    = rd_en;
        rd_idx_next     = rd_cnt_reg[IW-1:0];
        hit_found_next  = hit_found_reg;
        old_found_next  = old_found_reg;
        free_found_next = free_found_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;
        req_set_next    = req_set_reg;
        req_key_next    = req_key_reg;
        req_val_next    = req_val_reg;
        hit_idx_next    = hit_idx_reg;
        hit_age_next    = hit_age_reg;
        hit_val_next    = hit_val_reg;
        old_idx_next    = old_idx_reg;
        old_age_next    = old_age_reg;
        free_idx_next   = free_idx_reg;
        tgt_idx_next    = tgt_idx_reg;
        tgt_val_next    = tgt_val_reg;
        thresh_next     = thresh_reg;
        inc_all_next    = inc_all_reg;
        out_found_next  = out_found_reg;
        out_value_next  = out_value_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_set_next    = (op_t'(s_tuser) == OP_SET);
                    req_key_next    = s_tdata[KEY_BITS-1:0];
                    req_val_next    = s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
                    rd_cnt_next     = '0;
                    hit_found_next  = 1'b0;
                    old_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_pend_reg) begin
                    // first matching key
                    if (ent_valid && (ent_key == req_key_reg) && !hit_found_reg) begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = rd_idx_reg;
                        hit_age_next   = ent_age;
                        hit_val_next   = ent_val;
                    end
                    // oldest valid entry
                    if (ent_valid && (!old_found_reg || (ent_age > old_age_reg))) begin
                        old_found_next = 1'b1;
                        old_idx_next   = rd_idx_reg;
                        old_age_next   = ent_age;
                    end
                    // first free slot
                    if (!ent_valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                    if (rd_idx_reg == LAST_IDX) begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                rd_cnt_next = '0;
                if (hit_found_reg) begin
                    // refresh the hit entry
                    tgt_idx_next = hit_idx_reg;
                    tgt_val_next = req_set_reg ? req_val_reg : hit_val_reg;
                    thresh_next  = hit_age_reg;
                    inc_all_next = 1'b0;
                    state_next   = ST_UPDATE;
                end else if (req_set_reg) begin
                    // insert, evicting the oldest when at the limit
                    if (evict) begin
                        valid_next[old_idx_reg] = 1'b0;
                    end else begin
                        occ_next = occ_reg + CNT_W'(1);
                    end
                    valid_next[slot] = 1'b1;
                    tgt_idx_next     = slot;
                    tgt_val_next     = req_val_reg;
                    inc_all_next     = 1'b1;
                    state_next       = ST_UPDATE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_UPDATE: begin
                if (rd_pend_reg && (rd_idx_reg == LAST_IDX)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_found_next = hit_found_reg;
                    out_value_next = (hit_found_reg && !req_set_reg) ? hit_val_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            occ_reg        <= '0;
            cfg_reg        <= CFG_RESET;
            rd_cnt_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            old_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            occ_reg        <= occ_next;
            cfg_reg        <= cfg_next;
            rd_cnt_reg     <= rd_cnt_next;
            rd_pend_reg    <= rd_pend_next;
            hit_found_reg  <= hit_found_next;
            old_found_reg  <= old_found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        req_set_reg   <= req_set_next;
        req_key_reg   <= req_key_next;
        req_val_reg   <= req_val_next;
        hit_idx_reg   <= hit_idx_next;
        hit_age_reg   <= hit_age_next;
        hit_val_reg   <= hit_val_next;
        old_idx_reg   <= old_idx_next;
        old_age_reg   <= old_age_next;
        free_idx_reg  <= free_idx_next;
        tgt_idx_reg   <= tgt_idx_next;
        tgt_val_reg   <= tgt_val_next;
        thresh_reg    <= thresh_next;
        inc_all_reg   <= inc_all_next;
        out_found_reg <= out_found_next;
        out_value_reg <= out_value_next;
    end

endmodule

// ----- rtl/lkvc_check.sv -----
// port-level checks for the lru key-value cache, bound to the top level
module lkvc_check
    import lkvc_pkg::*;
#(
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input logic                                     aclk,
    input logic                                     aresetn,
    input logic                                     s_tvalid,
    input logic                                     s_tready,
    input logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
    input logic                                     s_tuser,
    input logic                                     m_tvalid,
    input logic                                     m_tready,
    input logic [((VALUE_BITS+7)/8)*8-1:0]          m_tdata,
    input logic                                     m_tuser
);

    logic [1:0] pend_reg, pend_next;
    logic       in_beat, out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // requests taken but not yet answered
    always_comb begin
        pend_next = pend_reg;
        if (in_beat && !out_beat) begin
            pend_next = pend_reg + 2'd1;
        end else if (out_beat && !in_beat) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_next_check: assert (pend_next != 2'd3)
                else $error("more than two requests outstanding");
            pend_reg <= pend_next;
        end
    end

    // every result beat answers a request
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pend_reg != 2'd0))
        else $error("result beat without an outstanding request");

    // one request at a time: busy right after taking one
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one is in work");

    // a miss carries a zero value
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("miss result with nonzero value");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind lru_key_value_cache lkvc_check #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_lkvc_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
